[rtl/core/dss_pkg.sv]
// Types and codes shared by the two-stack shared-array modules.
package dss_pkg;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	localparam int SIZE_BITS = 5;
	localparam int READ_BITS = 32;
	localparam int PUSH_BITS = 32;

	typedef struct packed {
		logic    push_en;
		logic    pop_en;
		logic    clear_en;
		logic    rd_en;
		logic    out_load;
		logic    out_use_ram;
		status_t stat;
	} dss_cmd_t;

	typedef struct packed {
		logic full;
		logic sel_empty;
	} dss_sts_t;

endpackage

[rtl/core/dual_stack_shared_array.sv]
// Two LIFO stacks sharing one slot RAM of SLOTS words: stack one grows up from
// slot 0, stack two grows down from slot SLOTS-1. Push, clear, a rejected push
// and a pop or peek on an empty stack load the response register directly; a pop or
// peek that returns data goes through the registered slot RAM read and ST_READ first.
// Each request gives one response transfer carrying the status, the word read
// and both sizes and flags after the request. The response sits in an output
// register, so the next request is taken while a response waits, unless a
// response is still stalled or ST_READ is active. Slots are not cleared by reset or clear.
module dual_stack_shared_array
	import dss_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  req_type,
	input  logic                        stack_sel,
	input  logic signed [PUSH_BITS-1:0] push_value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [1:0]                  status,
	output logic signed [READ_BITS-1:0] read_value,
	output logic [SIZE_BITS-1:0]        size_one,
	output logic [SIZE_BITS-1:0]        size_two,
	output logic                        empty_one,
	output logic                        empty_two,
	output logic                        all_full
);

	dss_cmd_t cmd;
	dss_sts_t sts;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dss_dp #(
		.SLOTS     (SLOTS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.stack_sel  (stack_sel),
		.push_value (push_value),
		.cmd        (cmd),
		.sts        (sts),
		.status     (status),
		.read_value (read_value),
		.size_one   (size_one),
		.size_two   (size_two),
		.empty_one  (empty_one),
		.empty_two  (empty_two),
		.all_full   (all_full)
	);

endmodule

[rtl/core/dss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/dss_ctrl.sv]
// Request sequencer: decodes requests, issues datapath commands, owns response valid.
module dss_ctrl
	import dss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_type,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  dss_sts_t   sts,
	output dss_cmd_t   cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q, rsp_valid_d;
	logic   out_free;
	logic   accept;
	req_t   req;

	assign req      = req_t'(req_type);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign accept   = (state_q == ST_IDLE) && req_valid && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req == REQ_POP || req == REQ_PEEK) && !sts.sel_empty) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.stat  = STAT_OK;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = !out_free;
				if (accept) begin
					unique case (req)
						REQ_PUSH: begin
							cmd.out_load = 1'b1;
							if (sts.full) begin
								cmd.stat = STAT_FULL;
							end else begin
								cmd.push_en = 1'b1;
							end
						end
						REQ_POP, REQ_PEEK: begin
							if (sts.sel_empty) begin
								cmd.stat     = STAT_EMPTY;
								cmd.out_load = 1'b1;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.pop_en = (req == REQ_POP);
							end
						end
						REQ_CLEAR: begin
							cmd.clear_en = 1'b1;
							cmd.out_load = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.out_load    = 1'b1;
				cmd.out_use_ram = 1'b1;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q && rsp_stall;
		if (cmd.out_load) begin
			rsp_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[rtl/core/dss_dp.sv]
// Datapath: stack counters, slot addressing, slot RAM and response register.
module dss_dp
	import dss_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 stack_sel,
	input  logic signed [PUSH_BITS-1:0] push_value,
	input  dss_cmd_t             cmd,
	output dss_sts_t             sts,
	output logic [1:0]           status,
	output logic signed [READ_BITS-1:0] read_value,
	output logic [SIZE_BITS-1:0] size_one,
	output logic [SIZE_BITS-1:0] size_two,
	output logic                 empty_one,
	output logic                 empty_two,
	output logic                 all_full
);

	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ADDR_W = $clog2(SLOTS);
	localparam logic [CNT_W:0]   SLOTS_W = (CNT_W + 1)'(SLOTS);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	logic [CNT_W-1:0]     cnt_one_q, cnt_two_q;
	logic [CNT_W-1:0]     cnt_one_d, cnt_two_d;
	logic [CNT_W:0]       held, held_d;
	logic [ADDR_W-1:0]    wr_addr, rd_addr;
	logic [WORD_BITS-1:0] wr_data, rd_data;

	logic [1:0]           status_q;
	logic [READ_BITS-1:0] read_value_q;
	logic [SIZE_BITS-1:0] size_one_q, size_two_q;
	logic                 empty_one_q, empty_two_q, all_full_q;

	assign held          = {1'b0, cnt_one_q} + {1'b0, cnt_two_q};
	assign sts.full      = (held >= SLOTS_W);
	assign sts.sel_empty = stack_sel ? (cnt_two_q == '0) : (cnt_one_q == '0);

	assign wr_addr = stack_sel ? ADDR_W'(SLOTS_C - CNT_W'(1) - cnt_two_q) : ADDR_W'(cnt_one_q);
	assign rd_addr = stack_sel ? ADDR_W'(SLOTS_C - cnt_two_q) : ADDR_W'(cnt_one_q - CNT_W'(1));
	assign wr_data = WORD_BITS'($unsigned(push_value));

	always_comb begin
		cnt_one_d = cnt_one_q;
		cnt_two_d = cnt_two_q;
		priority if (cmd.clear_en) begin
			cnt_one_d = '0;
			cnt_two_d = '0;
		end else if (cmd.push_en) begin
			if (stack_sel) begin
				cnt_two_d = cnt_two_q + CNT_W'(1);
			end else begin
				cnt_one_d = cnt_one_q + CNT_W'(1);
			end
		end else if (cmd.pop_en) begin
			if (stack_sel) begin
				cnt_two_d = cnt_two_q - CNT_W'(1);
			end else begin
				cnt_one_d = cnt_one_q - CNT_W'(1);
			end
		end else begin
			cnt_one_d = cnt_one_q;
			cnt_two_d = cnt_two_q;
		end
	end

	assign held_d = {1'b0, cnt_one_d} + {1'b0, cnt_two_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_one_q <= '0;
			cnt_two_q <= '0;
		end else begin
			cnt_one_q <= cnt_one_d;
			cnt_two_q <= cnt_two_d;
		end
	end

	dss_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.push_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q     <= cmd.stat;
			read_value_q <= cmd.out_use_ram ? READ_BITS'(rd_data) : '0;
			size_one_q   <= SIZE_BITS'(cnt_one_d);
			size_two_q   <= SIZE_BITS'(cnt_two_d);
			empty_one_q  <= (cnt_one_d == '0);
			empty_two_q  <= (cnt_two_d == '0);
			all_full_q   <= (held_d >= SLOTS_W);
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;
	assign size_one   = size_one_q;
	assign size_two   = size_two_q;
	assign empty_one  = empty_one_q;
	assign empty_two  = empty_two_q;
	assign all_full   = all_full_q;

endmodule

[verif/dss_result_check.sv]
// Checker for dual_stack_shared_array: tracks both stacks and compares every response.
module dss_result_check
	import dss_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  logic [1:0]                  req_type,
	input  logic                        stack_sel,
	input  logic signed [PUSH_BITS-1:0] push_value,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  logic [1:0]                  status,
	input  logic signed [READ_BITS-1:0] read_value,
	input  logic [SIZE_BITS-1:0]        size_one,
	input  logic [SIZE_BITS-1:0]        size_two,
	input  logic                        empty_one,
	input  logic                        empty_two,
	input  logic                        all_full,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]           status;
		logic [READ_BITS-1:0] read_value;
		logic [SIZE_BITS-1:0] size_one;
		logic [SIZE_BITS-1:0] size_two;
		logic                 empty_one;
		logic                 empty_two;
		logic                 all_full;
	} stack_result_t;

	logic [PUSH_BITS-1:0] slot_mem [SLOTS];
	int                   depth_one;
	int                   depth_two;
	stack_result_t        due_results [$];

	function automatic stack_result_t stack_apply(req_t op, logic sel, logic [PUSH_BITS-1:0] word);
		stack_result_t r;
		int            depth;
		r.status     = STAT_OK;
		r.read_value = '0;
		case (op)
			REQ_PUSH: begin
				if (depth_one + depth_two >= SLOTS) begin
					r.status = STAT_FULL;
				end else if (!sel) begin
					slot_mem[depth_one] = word;
					depth_one++;
				end else begin
					slot_mem[SLOTS - 1 - depth_two] = word;
					depth_two++;
				end
			end
			REQ_POP, REQ_PEEK: begin
				depth = sel ? depth_two : depth_one;
				if (depth == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.read_value = slot_mem[sel ? SLOTS - depth : depth - 1];
					if (op == REQ_POP) begin
						if (sel) begin
							depth_two--;
						end else begin
							depth_one--;
						end
					end
				end
			end
			default: begin
				depth_one = 0;
				depth_two = 0;
			end
		endcase
		r.size_one  = depth_one[SIZE_BITS-1:0];
		r.size_two  = depth_two[SIZE_BITS-1:0];
		r.empty_one = (depth_one == 0);
		r.empty_two = (depth_two == 0);
		r.all_full  = (depth_one + depth_two >= SLOTS);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t got;
		stack_result_t want;
		if (!arst_n) begin
			due_results.delete();
			depth_one   = 0;
			depth_two   = 0;
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// response first: a transfer on this edge never belongs to a request on the same edge
			if (rsp_valid && !rsp_stall) begin
				got = '{status, read_value, size_one, size_two, empty_one, empty_two, all_full};
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: response transfer with nothing pending: %p", $time, got);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.read_value !== want.read_value ||
					    got.size_one !== want.size_one || got.size_two !== want.size_two ||
					    got.empty_one !== want.empty_one || got.empty_two !== want.empty_two ||
					    got.all_full !== want.all_full) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: mismatch status %0d/%0d value %h/%h size %0d,%0d/%0d,%0d empty %b%b/%b%b full %b/%b (exp/got)",
								$time, want.status, got.status, want.read_value, got.read_value,
								want.size_one, want.size_two, got.size_one, got.size_two,
								want.empty_one, want.empty_two, got.empty_one, got.empty_two,
								want.all_full, got.all_full);
					end
				end
			end
			if (req_valid && !req_stall)
				due_results.push_back(stack_apply(req_t'(req_type), stack_sel, push_value));
			outstanding = due_results.size();
		end
	end

endmodule

[verif/dual_stack_shared_array_test.sv]
// Testbench top for dual_stack_shared_array: clock, reset, request and response traffic, verdict.
module dual_stack_shared_array_test;
	import dss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 1620;
	localparam int IDLE_LIMIT   = 2000;
	localparam int LONG_HOLD    = 64;
	localparam int DRAIN_CYCLES = 8;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_stall;
	logic [1:0]                  req_type;
	logic                        stack_sel;
	logic signed [PUSH_BITS-1:0] push_value;
	logic                        rsp_valid;
	logic                        rsp_stall;
	logic [1:0]                  status;
	logic signed [READ_BITS-1:0] read_value;
	logic [SIZE_BITS-1:0]        size_one;
	logic [SIZE_BITS-1:0]        size_two;
	logic                        empty_one;
	logic                        empty_two;
	logic                        all_full;

	int   mismatches;
	int   outstanding;
	int   send_idle_max;
	int   recv_idle_max;
	logic long_hold_pending;
	int   quiet_cycles;

	dual_stack_shared_array #(.SLOTS(SLOTS), .WORD_BITS(32)) dut (.*);

	dss_result_check #(.SLOTS(SLOTS)) check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: consecutive cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= IDLE_LIMIT) begin
				$display("FAIL dual_stack_shared_array");
				$finish;
			end
		end
	end

	task automatic send_request(req_t op, logic sel, logic [PUSH_BITS-1:0] word);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= op;
		stack_sel  <= sel;
		push_value <= word;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	function automatic logic [PUSH_BITS-1:0] pick_word();
		logic [PUSH_BITS-1:0] corner [4] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
		if ($urandom_range(0, 7) == 0)
			return corner[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	// response side
	initial begin
		int hold;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_pending) begin
				hold = LONG_HOLD;
				long_hold_pending = 1'b0;
			end else begin
				hold = $urandom_range(0, recv_idle_max);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	// request side and verdict
	initial begin
		int push_pct;
		int sel_pct;
		int roll;
		req_t op;
		arst_n            = 1'b0;
		req_valid         = 1'b0;
		req_type          = REQ_PUSH;
		stack_sel         = 1'b0;
		push_value        = '0;
		send_idle_max     = 15;
		recv_idle_max     = 15;
		long_hold_pending = 1'b0;
		quiet_cycles      = 0;
		push_pct          = 50;
		sel_pct           = 50;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty stacks, word extremes, peek and pop with data
		send_request(REQ_PEEK, 1'b0, $urandom);
		send_request(REQ_POP, 1'b1, $urandom);
		send_request(REQ_PUSH, 1'b0, 32'h7FFF_FFFF);
		send_request(REQ_PUSH, 1'b0, 32'h8000_0000);
		send_request(REQ_PUSH, 1'b1, 32'h0000_0000);
		send_request(REQ_PUSH, 1'b1, 32'hFFFF_FFFF);
		send_request(REQ_PEEK, 1'b0, $urandom);
		send_request(REQ_PEEK, 1'b1, $urandom);
		send_request(REQ_POP, 1'b0, $urandom);
		// fill the shared array, then push into a full array on both sides
		for (int k = 0; k < SLOTS - 3; k++)
			send_request(REQ_PUSH, k[0], $urandom);
		send_request(REQ_PUSH, 1'b0, $urandom);
		send_request(REQ_PUSH, 1'b1, $urandom);
		send_request(REQ_CLEAR, 1'b1, $urandom);
		send_request(REQ_POP, 1'b0, $urandom);
		send_request(REQ_PEEK, 1'b1, $urandom);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				push_pct = 25 * $urandom_range(1, 3);
				sel_pct  = 25 * $urandom_range(0, 4);
			end
			if (n == 400) begin
				send_idle_max = 0;
				recv_idle_max = 0;
			end
			if (n == 650) begin
				send_idle_max = 15;
				recv_idle_max = 15;
			end
			if (n == 900) begin
				long_hold_pending = 1'b1;
				send_idle_max     = 0;
			end
			if (n == 1000)
				send_idle_max = 15;
			if (n == 1200)
				wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < 2)
				op = REQ_CLEAR;
			else if (roll < 2 + push_pct)
				op = REQ_PUSH;
			else if (roll % 3 == 0)
				op = REQ_PEEK;
			else
				op = REQ_POP;
			send_request(op, ($urandom_range(0, 99) < sel_pct), pick_word());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS dual_stack_shared_array");
		else
			$display("FAIL dual_stack_shared_array");
		$finish;
	end

endmodule
